// File: hdl/fmr_pkg.sv
package fmr_pkg;

  localparam int MAX_PATTERN     = 32;
  localparam int MAX_REPLACEMENT = 32;

  localparam int BYTE_W    = 8;
  localparam int PAT_LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int REP_LEN_W = $clog2(MAX_REPLACEMENT + 1);
  localparam int REP_IDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  // Kind of an input word, carried on in_tuser
  localparam logic [1:0] FUNC_TEXT  = 2'd0;
  localparam logic [1:0] FUNC_PAT   = 2'd1;
  localparam logic [1:0] FUNC_REP   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_REPL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  // Per-cell strobes from the sequencer
  typedef struct packed {
    logic pat_we;
    logic win_we;
    logic win_shift;
  } cell_ctl_t;

endpackage

// File: hdl/fmr_cell.sv
module fmr_cell (
  input  logic                       clk,
  input  fmr_pkg::cell_ctl_t         ctl,
  input  logic [fmr_pkg::BYTE_W-1:0] data_d,
  input  logic [fmr_pkg::BYTE_W-1:0] win_next,
  output logic [fmr_pkg::BYTE_W-1:0] win_q,
  output logic                       eq
);

  logic [fmr_pkg::BYTE_W-1:0] pat_r;
  logic [fmr_pkg::BYTE_W-1:0] win_r;

  always_ff @(posedge clk) begin
    if (ctl.pat_we) begin
      pat_r <= data_d;
    end
    // load a new text byte, or take the neighbor's byte as the window advances
    if (ctl.win_we) begin
      win_r <= data_d;
    end else if (ctl.win_shift) begin
      win_r <= win_next;
    end
  end

  assign win_q = win_r;
  assign eq    = (win_r == pat_r);

endmodule

// File: hdl/first_match_replace_stream.sv
// Streaming find-and-replace of the first occurrence of a pattern.
// Input channel (in_*): each word carries a kind on in_tuser (text byte,
// append pattern byte, append replacement byte, clear both stores), a byte
// on in_tdata and, for text, in_tlast marking the final byte of a string.
// Result channel (out_*): out_tdata is the emitted byte, out_tuser is 1 when
// the byte is valid (0 for a bare end marker), out_tlast closes the text.
// Store loads complete as they are accepted. A text byte is accepted, then
// gets one compare step across the row of cells; no new word is taken until
// that step and any replacement or flush it starts are done. A match streams
// the replacement (up to 32 bytes) out of its store at one byte per cycle
// while the receiver keeps up; a final byte flushes the pending window at
// one byte per cycle, likewise. Both rates come from the single output
// register, which takes one word per cycle while not stalled.
// A single output register decouples the channels; when the receiver
// stalls, a step with a word to emit holds the sequencer and in_tready stays
// low until the register frees. Store loads are still taken while idle.
// Reset (rst_n low, synchronous) empties both stores and the window and
// drops any pending result word.
module first_match_replace_stream (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] func
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // has_byte
  output logic       out_tlast   // end_of_text
);

  localparam int NP = fmr_pkg::MAX_PATTERN;
  localparam int NR = fmr_pkg::MAX_REPLACEMENT;
  localparam int BW = fmr_pkg::BYTE_W;
  localparam int PW = fmr_pkg::PAT_LEN_W;
  localparam int RW = fmr_pkg::REP_LEN_W;
  localparam int IW = fmr_pkg::REP_IDX_W;

  fmr_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] plen_r, plen_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [RW-1:0] rlen_r, rlen_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic          replaced_r, replaced_nxt;
  logic [BW-1:0] item_byte_r;
  logic          item_last_r;
  logic [BW-1:0] rep_r [NR];
  logic [BW-1:0] rep_q_r;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_byte_r;
  logic          out_has_r;
  logic          out_eot_r;

  logic          in_acc;
  logic          out_free;
  logic          emit;
  logic [BW-1:0] emit_byte;
  logic          emit_has;
  logic          emit_eot;
  logic          push;
  logic          shift;
  logic          rep_we;
  logic          match;
  logic          rep_final;

  logic [BW-1:0] win_q [NP];
  logic [NP-1:0] eq_vec;
  logic [NP-1:0] live_vec;

  assign in_tready = (state_r == fmr_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign match     = &(eq_vec | ~live_vec);
  assign rep_final = ((RW'(ridx_r) + RW'(1)) == rlen_r);

  // Row of cells: cell i holds pattern byte i and window byte i; the window
  // advances toward cell 0, which always holds the oldest pending byte.
  for (genvar i = 0; i < NP; i++) begin : g_cell
    fmr_pkg::cell_ctl_t ctl;
    logic [BW-1:0]      nxt_byte;

    if (i == NP - 1) begin : g_tail
      assign nxt_byte = '0;
    end else begin : g_body
      assign nxt_byte = win_q[i+1];
    end

    assign ctl.pat_we    = in_acc && (in_tuser == fmr_pkg::FUNC_PAT) && (plen_r == PW'(i));
    assign ctl.win_we    = push && (fill_r == PW'(i));
    assign ctl.win_shift = shift;
    assign live_vec[i]   = (PW'(i) < plen_r);

    fmr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .data_d   (in_tdata),
      .win_next (nxt_byte),
      .win_q    (win_q[i]),
      .eq       (eq_vec[i])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    plen_nxt     = plen_r;
    fill_nxt     = fill_r;
    rlen_nxt     = rlen_r;
    ridx_nxt     = ridx_r;
    replaced_nxt = replaced_r;
    emit         = 1'b0;
    emit_byte    = win_q[0];
    emit_has     = 1'b1;
    emit_eot     = 1'b0;
    push         = 1'b0;
    shift        = 1'b0;
    rep_we       = 1'b0;

    case (state_r)
      fmr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            fmr_pkg::FUNC_TEXT: begin
              // bytes after a replacement, or with no pattern, skip the window
              if (!replaced_r && (plen_r != '0)) begin
                push     = 1'b1;
                fill_nxt = fill_r + PW'(1);
              end
              state_nxt = fmr_pkg::S_CMP;
            end
            fmr_pkg::FUNC_PAT: begin
              if (plen_r < PW'(NP)) begin
                plen_nxt = plen_r + PW'(1);
              end
              fill_nxt     = '0;
              replaced_nxt = 1'b0;
            end
            fmr_pkg::FUNC_REP: begin
              if (rlen_r < RW'(NR)) begin
                rep_we   = 1'b1;
                rlen_nxt = rlen_r + RW'(1);
              end
              fill_nxt     = '0;
              replaced_nxt = 1'b0;
            end
            fmr_pkg::FUNC_CLEAR: begin
              plen_nxt     = '0;
              rlen_nxt     = '0;
              fill_nxt     = '0;
              replaced_nxt = 1'b0;
            end
            default: begin
              state_nxt = fmr_pkg::S_IDLE;
            end
          endcase
        end
      end

      fmr_pkg::S_CMP: begin
        if (replaced_r || (plen_r == '0)) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_byte = item_byte_r;
            emit_eot  = item_last_r;
            if (item_last_r) begin
              replaced_nxt = 1'b0;
            end
            state_nxt = fmr_pkg::S_IDLE;
          end
        end else if (fill_r == plen_r) begin
          if (match) begin
            fill_nxt = '0;
            if (rlen_r != '0) begin
              ridx_nxt  = '0;
              state_nxt = fmr_pkg::S_REPL;
            end else begin
              // empty replacement: drop the window; a final byte still needs a marker
              replaced_nxt = 1'b1;
              state_nxt    = item_last_r ? fmr_pkg::S_FLUSH : fmr_pkg::S_IDLE;
            end
          end else if (out_free) begin
            emit     = 1'b1;
            emit_eot = item_last_r && (fill_r == PW'(1));
            shift    = 1'b1;
            fill_nxt = fill_r - PW'(1);
            if (item_last_r && (fill_r != PW'(1))) begin
              state_nxt = fmr_pkg::S_FLUSH;
            end else begin
              state_nxt = fmr_pkg::S_IDLE;
            end
            if (item_last_r && (fill_r == PW'(1))) begin
              replaced_nxt = 1'b0;
            end
          end
        end else begin
          state_nxt = item_last_r ? fmr_pkg::S_FLUSH : fmr_pkg::S_IDLE;
        end
      end

      fmr_pkg::S_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = rep_q_r;
          emit_eot  = item_last_r && rep_final;
          ridx_nxt  = ridx_r + IW'(1);
          if (rep_final) begin
            replaced_nxt = !item_last_r;
            state_nxt    = fmr_pkg::S_IDLE;
          end
        end
      end

      fmr_pkg::S_FLUSH: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_eot = (fill_r <= PW'(1));
          if (fill_r == '0) begin
            // nothing pending: bare end marker
            emit_byte    = '0;
            emit_has     = 1'b0;
            replaced_nxt = 1'b0;
            state_nxt    = fmr_pkg::S_IDLE;
          end else begin
            shift    = 1'b1;
            fill_nxt = fill_r - PW'(1);
            if (fill_r == PW'(1)) begin
              replaced_nxt = 1'b0;
              state_nxt    = fmr_pkg::S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = fmr_pkg::S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmr_pkg::S_IDLE;
      plen_r      <= '0;
      fill_r      <= '0;
      rlen_r      <= '0;
      ridx_r      <= '0;
      replaced_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      fill_r      <= fill_nxt;
      rlen_r      <= rlen_nxt;
      ridx_r      <= ridx_nxt;
      replaced_r  <= replaced_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold the current text word, the replacement store and the result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_byte_r <= in_tdata;
      item_last_r <= in_tlast;
    end
    if (in_acc && rep_we) begin
      rep_r[rlen_r[IW-1:0]] <= in_tdata;
    end
    // fetch the replacement byte that the next emit in S_REPL sends
    rep_q_r <= rep_r[ridx_nxt];
    if (emit) begin
      out_byte_r <= emit_byte;
      out_has_r  <= emit_has;
      out_eot_r  <= emit_eot;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_eot_r;

`ifndef SYNTHESIS
  a_fill_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= plen_r)
    else $error("window fill exceeds pattern length");

  a_repl_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmr_pkg::S_REPL) |-> (RW'(ridx_r) < rlen_r))
    else $error("replacement index beyond stored length");

  a_store_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser != fmr_pkg::FUNC_TEXT)) |=> ((fill_r == '0) && !replaced_r))
    else $error("store update did not end the text");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_byte_r) && $stable(out_eot_r)))
    else $error("result word overwritten while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmr_pkg::S_REPL || state_r == fmr_pkg::S_FLUSH) |-> !in_tready)
    else $error("input taken while emitting");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  // Worst case: ~250 words with up to 32 results each, most results stalled.
  localparam int CYCLE_LIMIT  = 400000;
  // Longest burst after the last word: a 32-byte flush plus the compare step.
  localparam int DRAIN_CYCLES = 80;

  // One result word as it leaves the block
  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eot;
  } out_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] data_byte
  logic [1:0] in_tuser;    // [1:0] func
  logic       in_tlast;    // last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic       out_tuser;   // has_byte
  logic       out_tlast;   // end_of_text

  // Idle rates in percent, changed between test phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int words_sent     = 0;

  // Predictor state: the two stores, the pending window, the replaced flag
  logic [7:0] pat_mem [fmr_pkg::MAX_PATTERN];
  int         pat_len;
  logic [7:0] rep_mem [fmr_pkg::MAX_REPLACEMENT];
  int         rep_len;
  logic [7:0] win_mem [fmr_pkg::MAX_PATTERN];
  int         win_fill;
  bit         replaced;

  // Result words still owed by the block, oldest first
  out_word_t  owed_words [$];

  first_match_replace_stream i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Receiver: toggle backpressure at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void owe_word(logic [7:0] data, logic has_byte, logic eot);
    out_word_t w;
    w.data     = data;
    w.has_byte = has_byte;
    w.eot      = eot;
    owed_words.push_back(w);
  endfunction

  // Advance the predictor by one accepted input word and queue its results.
  function automatic void replace_step(logic [1:0] func, logic [7:0] data, logic last);
    int        base;
    bit        same;
    out_word_t w;
    base = owed_words.size();
    case (func)
      fmr_pkg::FUNC_PAT: begin
        if (pat_len < fmr_pkg::MAX_PATTERN) begin
          pat_mem[pat_len] = data;
          pat_len++;
        end
        win_fill = 0;
        replaced = 0;
      end
      fmr_pkg::FUNC_REP: begin
        if (rep_len < fmr_pkg::MAX_REPLACEMENT) begin
          rep_mem[rep_len] = data;
          rep_len++;
        end
        win_fill = 0;
        replaced = 0;
      end
      fmr_pkg::FUNC_CLEAR: begin
        pat_len  = 0;
        rep_len  = 0;
        win_fill = 0;
        replaced = 0;
      end
      default: begin
        // Pass straight through once replaced, or with no pattern at all
        if (replaced || pat_len == 0) begin
          owe_word(data, 1'b1, last);
          if (last) begin
            win_fill = 0;
            replaced = 0;
          end
          return;
        end
        if (win_fill < fmr_pkg::MAX_PATTERN) begin
          win_mem[win_fill] = data;
          win_fill++;
        end
        if (win_fill >= pat_len) begin
          same = 1;
          for (int i = 0; i < pat_len; i++)
            if (win_mem[i] != pat_mem[i]) same = 0;
          if (same) begin
            for (int i = 0; i < rep_len; i++) owe_word(rep_mem[i], 1'b1, 1'b0);
            win_fill = 0;
            replaced = 1;
          end else begin
            owe_word(win_mem[0], 1'b1, 1'b0);
            for (int i = 1; i < win_fill; i++) win_mem[i - 1] = win_mem[i];
            win_fill--;
          end
        end
        if (last) begin
          // Flush the window; tag the final word, or send a bare end marker
          for (int i = 0; i < win_fill; i++) owe_word(win_mem[i], 1'b1, 1'b0);
          if (owed_words.size() == base) begin
            owe_word(8'h00, 1'b0, 1'b1);
          end else begin
            w = owed_words.pop_back();
            w.eot = 1'b1;
            owed_words.push_back(w);
          end
          win_fill = 0;
          replaced = 0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: compare every accepted result word with the oldest owed one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_words.size() == 0) begin
        $error("unexpected word: out_byte %0h has_byte %0b end_of_text %0b",
               out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want = owed_words.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.has_byte) begin
          $error("has_byte: expected %0b, got %0b", want.has_byte, out_tuser);
          error_count++;
        end
        if (out_tlast !== want.eot) begin
          $error("end_of_text: expected %0b, got %0b", want.eot, out_tlast);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: drive one word at the falling edge, hold it until accepted
  // ---------------------------------------------------------------------------

  task automatic send_word(logic [1:0] func, logic [7:0] data, logic last);
    // Insert idle cycles ahead of the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = data;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replace_step(func, data, last);
    words_sent++;
    @(negedge clk);
  endtask

  // Bias text toward pattern bytes so partial matches happen often.
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(3))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return (pat_len > 0) ? pat_mem[$urandom_range(pat_len - 1)]
                                    : 8'($urandom_range(255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // No pattern loaded: every text byte passes straight through.
  task automatic test_empty_pattern();
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'hFF, 1'b1);
  endtask

  // Match on the last byte with no replacement: expect a bare end marker.
  task automatic test_bare_end_marker();
    send_word(fmr_pkg::FUNC_PAT, 8'hFF, 1'b1);
    send_word(fmr_pkg::FUNC_TEXT, 8'hFF, 1'b1);
  endtask

  // Replace the first match only; a later match passes, a partial one flushes.
  task automatic test_first_match_only();
    send_word(fmr_pkg::FUNC_CLEAR, 8'hFF, 1'b1);
    send_word(fmr_pkg::FUNC_PAT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_PAT, 8'hFF, 1'b0);
    send_word(fmr_pkg::FUNC_REP, 8'hAA, 1'b0);
    send_word(fmr_pkg::FUNC_REP, 8'h55, 1'b1);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'hFF, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'hFF, 1'b1);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b1);
  endtask

  // A store update in the middle of a text drops the pending window.
  task automatic test_mid_text_change();
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_REP, 8'h01, 1'b1);
    send_word(fmr_pkg::FUNC_TEXT, 8'hFF, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b1);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_CLEAR, 8'h00, 1'b0);
    send_word(fmr_pkg::FUNC_TEXT, 8'h00, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random sessions: clear, load both stores, then stream a few texts
  // ---------------------------------------------------------------------------

  task automatic test_random(int send_pct, int recv_pct, int word_target, bit start_full);
    int  start;
    int  p_want;
    int  r_want;
    int  n_texts;
    int  len;
    int  pos;
    int  abort_at;
    bit  embed;
    logic [7:0] data;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = words_sent;
    while (words_sent - start < word_target) begin
      // Pick store sizes: overfull once, otherwise short and now and then empty
      if (start_full) begin
        p_want     = fmr_pkg::MAX_PATTERN + 1;
        r_want     = fmr_pkg::MAX_REPLACEMENT + 1;
        n_texts    = 1;
        start_full = 0;
      end else begin
        p_want  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
        r_want  = $urandom_range(0, 4);
        n_texts = $urandom_range(1, 3);
      end
      send_word(fmr_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      for (int i = 0; i < p_want; i++)
        send_word(fmr_pkg::FUNC_PAT, pick_text_byte(), 1'($urandom_range(1)));
      for (int i = 0; i < r_want; i++)
        send_word(fmr_pkg::FUNC_REP, 8'($urandom_range(255)), 1'($urandom_range(1)));

      repeat (n_texts) begin
        len = (pat_len > 5) ? pat_len + $urandom_range(0, 4) : $urandom_range(1, 12);
        embed = (pat_len > 0) && ($urandom_range(9) < 6 || pat_len >= fmr_pkg::MAX_PATTERN);
        pos = embed ? $urandom_range(0, len - pat_len) : 0;
        // Break one text in ten with a store update before its end
        abort_at = ($urandom_range(9) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int k = 0; k < abort_at; k++) begin
          if (embed && k >= pos && k < pos + pat_len) data = pat_mem[k - pos];
          else data = pick_text_byte();
          send_word(fmr_pkg::FUNC_TEXT, data, k == len - 1);
        end
        if (abort_at < len)
          send_word($urandom_range(1) ? fmr_pkg::FUNC_PAT : fmr_pkg::FUNC_REP,
                    8'($urandom_range(255)), 1'($urandom_range(1)));
      end

      // Noise: a few words of any kind
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          data = 8'($urandom_range(255));
          case ($urandom_range(3))
            0:       send_word(fmr_pkg::FUNC_TEXT, data, 1'($urandom_range(1)));
            1:       send_word(fmr_pkg::FUNC_PAT, data, 1'($urandom_range(1)));
            2:       send_word(fmr_pkg::FUNC_REP, data, 1'($urandom_range(1)));
            default: send_word(fmr_pkg::FUNC_CLEAR, data, 1'($urandom_range(1)));
          endcase
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pat_len   = 0;
    rep_len   = 0;
    win_fill  = 0;
    replaced  = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = fmr_pkg::FUNC_TEXT;
    in_tlast  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Slow receiver first, for the directed part too
    send_idle_pct  = 7;
    recv_stall_pct = 67;
    test_empty_pattern();
    test_bare_end_marker();
    test_first_match_only();
    test_mid_text_change();

    test_random(7, 67, 60, 1'b1);
    test_random(67, 7, 12, 1'b0);
    test_random(0, 0, 12, 1'b0);

    // Release the input and wait for every owed word
    in_tvalid = 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
